>>> rtl/pwmr_pkg.sv
// shared types, constants and status codes of the pulse-width manchester receiver
package pwmr_pkg;

  localparam int          CT_W           = 16;
  localparam int          RUN_W          = 18;
  localparam int          CNT_W          = 12;
  localparam int          MAX_CHIPS_DEF  = 2048;
  localparam logic [15:0] CHIP_TICKS_RST = 16'd1000;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_LOW    = 2'd1;
  localparam logic [1:0] ST_BADLEN = 2'd2;
  localparam logic [1:0] ST_OVF    = 2'd3;

  typedef struct packed {
    logic line_level;
    logic restart;
  } item_t;

  typedef struct packed {
    logic             bit_valid;
    logic             bit_value;
    logic             frame_end;
    logic [1:0]       frame_status;
    logic [CNT_W-1:0] chip_count;
  } result_t;

endpackage

>>> rtl/pwmr_in_if.sv
// request channel carrying line samples into the receiver
interface pwmr_in_if;
  logic valid;
  logic ready;
  logic line_level;
  logic restart;

  modport source (output valid, output line_level, output restart, input ready);
  modport sink   (input valid, input line_level, input restart, output ready);
endinterface

>>> rtl/pwmr_out_if.sv
// result channel carrying decoded bits and frame status out of the receiver
interface pwmr_out_if;
  import pwmr_pkg::*;
  logic             valid;
  logic             ready;
  logic             bit_valid;
  logic             bit_value;
  logic             frame_end;
  logic [1:0]       frame_status;
  logic [CNT_W-1:0] chip_count;

  modport source (output valid, output bit_valid, output bit_value, output frame_end,
                  output frame_status, output chip_count, input ready);
  modport sink   (input valid, input bit_valid, input bit_value, input frame_end,
                  input frame_status, input chip_count, output ready);
endinterface

>>> rtl/pwmr_core.sv
// run classification, chip pairing and frame end logic with the receiver state
module pwmr_core #(
  parameter int MAX_CHIPS = pwmr_pkg::MAX_CHIPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            advance,
  input  pwmr_pkg::item_t                 item,
  input  logic [pwmr_pkg::CT_W-1:0]       c1,
  input  logic [pwmr_pkg::CT_W+1:0]       c3,
  input  logic [pwmr_pkg::CT_W+2:0]       c5,
  output pwmr_pkg::result_t               res,
  output logic                            has_res
);
  import pwmr_pkg::*;

  localparam int SEEN_W = $clog2(MAX_CHIPS + 1);
  localparam int SUM_W  = SEEN_W + 1;
  localparam int TW_W   = RUN_W + 1;
  localparam logic [SUM_W-1:0] MAX_S   = SUM_W'(MAX_CHIPS);
  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  logic              held_r, pend_r, active_r;
  logic [RUN_W-1:0]  run_r;
  logic [SEEN_W-1:0] seen_r;

  logic              held_nxt, pend_nxt, active_nxt;
  logic [RUN_W-1:0]  run_nxt, run_inc;
  logic [SEEN_W-1:0] seen_nxt;
  logic [TW_W-1:0]   twice;
  logic              le1, le3, gt5, two_chips, odd;
  logic [SUM_W-1:0]  seen_ext, total, push_sum;
  result_t           fin, res_nxt;
  logic              do_end;

  function automatic logic [CNT_W-1:0] to_cnt(input logic [SUM_W-1:0] v);
    logic [SUM_W+CNT_W-1:0] w;
    w = {{CNT_W{1'b0}}, v};
    return w[CNT_W-1:0];
  endfunction

  assign run_inc   = (run_r == RUN_MAX) ? run_r : run_r + RUN_W'(1);
  assign twice     = {run_inc, 1'b0};
  assign le1       = twice <= TW_W'(c1);
  assign le3       = twice <= TW_W'(c3);
  assign gt5       = twice > c5;
  assign two_chips = !le3;
  assign odd       = seen_r[0];
  assign seen_ext  = {1'b0, seen_r};
  assign total     = seen_ext + SUM_W'(3);
  assign push_sum  = seen_ext + (two_chips ? SUM_W'(2) : SUM_W'(1));

  // frame end result: three closing chips of the held level are counted
  always_comb begin
    fin = '0;
    fin.frame_end = 1'b1;
    priority if (total > MAX_S) begin
      fin.frame_status = ST_OVF;
      fin.chip_count   = to_cnt(seen_ext);
    end else if (!held_r) begin
      fin.frame_status = ST_LOW;
      fin.chip_count   = to_cnt(total);
    end else if (total[5:0] == 6'd3) begin
      fin.frame_status = ST_OK;
      fin.chip_count   = to_cnt(seen_ext);
    end else if (total[5:0] == 6'd2) begin
      // pending chip plus a high chip closes a last pair, which is a 0
      fin.frame_status = ST_OK;
      fin.chip_count   = to_cnt(seen_ext + SUM_W'(1));
      fin.bit_valid    = odd;
    end else begin
      fin.frame_status = ST_BADLEN;
      fin.chip_count   = to_cnt(total);
    end
  end

  always_comb begin
    held_nxt   = held_r;
    pend_nxt   = pend_r;
    active_nxt = active_r;
    run_nxt    = run_r;
    seen_nxt   = seen_r;
    res_nxt    = '0;
    do_end     = 1'b0;
    has_res    = 1'b0;
    if (item.restart) begin
      held_nxt   = 1'b0;
      pend_nxt   = 1'b0;
      active_nxt = 1'b1;
      run_nxt    = '0;
      seen_nxt   = '0;
    end else if (active_r) begin
      run_nxt = run_inc;
      if (item.line_level == held_r) begin
        do_end = gt5;
      end else if (!le1) begin
        if (gt5) begin
          do_end = 1'b1;
        end else if (push_sum > MAX_S) begin
          active_nxt           = 1'b0;
          has_res              = 1'b1;
          res_nxt.frame_end    = 1'b1;
          res_nxt.frame_status = ST_OVF;
          res_nxt.chip_count   = to_cnt(seen_ext);
        end else begin
          seen_nxt = push_sum[SEEN_W-1:0];
          held_nxt = item.line_level;
          run_nxt  = '0;
          if (two_chips || !odd) begin
            pend_nxt = held_r;
          end
          if (two_chips || odd) begin
            has_res           = 1'b1;
            res_nxt.bit_valid = 1'b1;
            res_nxt.bit_value = odd & pend_r & ~held_r;
          end
        end
      end
      if (do_end) begin
        active_nxt = 1'b0;
        has_res    = 1'b1;
        res_nxt    = fin;
      end
    end
  end

  assign res = res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= 1'b0;
      pend_r   <= 1'b0;
      active_r <= 1'b0;
      run_r    <= '0;
      seen_r   <= '0;
    end else if (advance) begin
      held_r   <= held_nxt;
      pend_r   <= pend_nxt;
      active_r <= active_nxt;
      run_r    <= run_nxt;
      seen_r   <= seen_nxt;
    end
  end

endmodule

>>> rtl/pulse_width_manchester_receiver.sv
// top level of the pulse-width manchester receiver: request and result registers around the core
// a request is held in the request register, passes the core and lands in the result register
// one request per cycle, set by the single pass through the core between registers,
// while its result has room; a request that yields no result still passes the core
// reset (rst_n low, synchronous): registers empty, no frame active, chip_ticks back to 1000
module pulse_width_manchester_receiver #(
  parameter int MAX_CHIPS = pwmr_pkg::MAX_CHIPS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  pwmr_in_if.sink                   in_ch,
  pwmr_out_if.source                out_ch,
  input  logic                      cfg_we,
  input  logic [pwmr_pkg::CT_W-1:0] cfg_wdata
);
  import pwmr_pkg::*;

  // chip period and its 3x and 5x multiples, formed once at write time
  // so the per-sample compares see plain registers
  logic [CT_W-1:0] c1_r;
  logic [CT_W+1:0] c3_r;
  logic [CT_W+2:0] c5_r;

  // request register
  logic  in_valid_r;
  item_t in_item_r;

  // result register
  logic    out_valid_r;
  result_t out_res_r;

  result_t core_res;
  logic    core_has_res;
  logic    out_free;
  logic    advance;

  // the held request moves through the core when its result (if any) has room;
  // a request with no result never waits on the output side
  assign out_free    = !out_valid_r || out_ch.ready;
  assign advance     = in_valid_r && (!core_has_res || out_free);
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= CHIP_TICKS_RST;
      c3_r <= (CT_W+2)'(CHIP_TICKS_RST) * (CT_W+2)'(3);
      c5_r <= (CT_W+3)'(CHIP_TICKS_RST) * (CT_W+3)'(5);
    end else if (cfg_we) begin
      c1_r <= cfg_wdata;
      c3_r <= (CT_W+2)'({cfg_wdata, 1'b0}) + (CT_W+2)'(cfg_wdata);
      c5_r <= (CT_W+3)'({cfg_wdata, 2'b00}) + (CT_W+3)'(cfg_wdata);
    end
  end

  // request register: loads whenever it is empty or draining this cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_item_r.line_level <= in_ch.line_level;
      in_item_r.restart    <= in_ch.restart;
    end
  end

  pwmr_core #(
    .MAX_CHIPS (MAX_CHIPS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_item_r),
    .c1      (c1_r),
    .c3      (c3_r),
    .c5      (c5_r),
    .res     (core_res),
    .has_res (core_has_res)
  );

  // result register: filled by a request that produces a result, drained by out ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && core_has_res) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_has_res) begin
      out_res_r <= core_res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.bit_valid    = out_res_r.bit_valid;
  assign out_ch.bit_value    = out_res_r.bit_value;
  assign out_ch.frame_end    = out_res_r.frame_end;
  assign out_ch.frame_status = out_res_r.frame_status;
  assign out_ch.chip_count   = out_res_r.chip_count;

  // every result carries a bit, a frame end or both
  a_res_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.bit_valid || out_res_r.frame_end))
    else $error("empty result in result register");

  // a nonzero status only comes with a frame end
  a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.frame_status != ST_OK) |-> out_res_r.frame_end)
    else $error("frame status without frame end");

  // a 1 bit is never given outside a valid bit
  a_bit_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.bit_value) |-> out_res_r.bit_valid)
    else $error("bit value set without bit valid");

  // a held request that cannot move stays in the request register
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> in_valid_r)
    else $error("request dropped while stalled");

endmodule
